/* design/shb_pkg.sv */
// ----------------------------------------------------------------------------
// shb_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package shb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } shb_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shb_out_t;

  // Source of the byte shifted into the block window
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      push;        // shift one byte into the block window
    byte_sel_e sel;
    logic      cap_len;     // capture message bit length
    logic      comp_start;  // load working variables from chain value
    logic      round;       // run one compression round
    logic [5:0] rnd;        // round number
    logic      fold;        // add working variables into chain value
    logic      rotate;      // advance digest output word
    logic      restart;     // back to initial hash values and counts
  } shb_cmd_t;

  typedef struct packed {
    logic pos_55;
    logic pos_63;
  } shb_sts_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* design/shb_datapath.sv */
// ----------------------------------------------------------------------------
// shb_datapath
// Block window, byte position, bit length, chain value and round logic.
// ----------------------------------------------------------------------------
module shb_datapath import shb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  shb_cmd_t    cmd_i,
  input  logic [7:0]  data_byte_i,
  output shb_sts_t    sts_o,
  output logic [31:0] digest_word_o
);

  // 16-word window: bytes shift in at the low end, w[t] sits at the top
  logic [511:0] blk_q, blk_d;
  logic [5:0]   pos_q, pos_d;
  logic [54:0]  nblk_q, nblk_d;
  logic [63:0]  len_q, len_d;
  logic [31:0]  h_q [8];
  logic [31:0]  h_d [8];
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];

  logic [7:0]  push_byte;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] ch, maj, t1, t2;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_DATA: push_byte = data_byte_i;
      SEL_MARK: push_byte = PadByte;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
      default:  push_byte = 8'h00;
    endcase
  end

  assign w0    = blk_q[511:480];
  assign w1    = blk_q[479:448];
  assign w9    = blk_q[223:192];
  assign w14   = blk_q[63:32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[cmd_i.rnd] + w0;
  assign t2  = big_sigma0(v_q[0]) + maj;

  always_comb begin
    blk_d  = blk_q;
    pos_d  = pos_q;
    nblk_d = nblk_q;
    len_d  = len_q;
    h_d    = h_q;
    v_d    = v_q;
    if (cmd_i.push) begin
      blk_d = {blk_q[503:0], push_byte};
      pos_d = pos_q + 6'd1;
      if (pos_q == 6'd63) begin
        nblk_d = nblk_q + 55'd1;
      end
    end else if (cmd_i.round) begin
      blk_d = {blk_q[479:0], w_new};
    end
    if (cmd_i.cap_len) begin
      // whole blocks are multiples of 512 bits, so no adder is needed
      len_d = {nblk_q, pos_q, 3'b000};
    end
    if (cmd_i.comp_start) begin
      v_d = h_q;
    end else if (cmd_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
    if (cmd_i.restart) begin
      h_d    = InitH;
      pos_d  = '0;
      nblk_d = '0;
    end else if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end else if (cmd_i.rotate) begin
      for (int i = 0; i < 7; i++) begin
        h_d[i] = h_q[i+1];
      end
      h_d[7] = h_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nblk_q <= '0;
      h_q    <= InitH;
    end else begin
      pos_q  <= pos_d;
      nblk_q <= nblk_d;
      h_q    <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    len_q <= len_d;
    v_q   <= v_d;
  end

  assign sts_o.pos_55  = (pos_q == 6'd55);
  assign sts_o.pos_63  = (pos_q == 6'd63);
  assign digest_word_o = h_q[0];

endmodule

/* design/shb_ctrl.sv */
// ----------------------------------------------------------------------------
// shb_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module shb_ctrl import shb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  shb_in_t    in_data_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] word_idx_o,
  input  shb_sts_t   sts_i,
  output shb_cmd_t   cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StComp = 3'd2;
  localparam logic [2:0] StFold = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam logic [1:0] PhMark = 2'd0;
  localparam logic [1:0] PhZero = 2'd1;
  localparam logic [1:0] PhLen  = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] ph_q, ph_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       fin_q, fin_d;       // message ended, padding in progress
  logic       lastblk_q, lastblk_d; // block with the length is compressing

  always_comb begin
    cmd_o     = '0;
    cmd_o.sel = SEL_DATA;
    cmd_o.rnd = rnd_q;
    state_d   = state_q;
    ph_d      = ph_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    fin_d     = fin_q;
    lastblk_d = lastblk_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_data_i.byte_valid) begin
            cmd_o.push = 1'b1;
            if (sts_i.pos_63) begin
              cmd_o.comp_start = 1'b1;
              state_d          = StComp;
            end
          end
          if (in_data_i.last) begin
            fin_d = 1'b1;
            ph_d  = PhMark;
            if (!(in_data_i.byte_valid && sts_i.pos_63)) begin
              state_d = StPad;
            end
          end
        end
      end
      StPad: begin
        cmd_o.push = 1'b1;
        unique case (ph_q)
          PhMark: begin
            cmd_o.sel     = SEL_MARK;
            cmd_o.cap_len = 1'b1;
          end
          PhZero:  cmd_o.sel = SEL_ZERO;
          PhLen:   cmd_o.sel = SEL_LEN;
          default: cmd_o.sel = SEL_ZERO;
        endcase
        if (ph_q != PhLen) begin
          ph_d = sts_i.pos_55 ? PhLen : PhZero;
        end else if (sts_i.pos_63) begin
          lastblk_d = 1'b1;
        end
        if (sts_i.pos_63) begin
          cmd_o.comp_start = 1'b1;
          state_d          = StComp;
        end
      end
      StComp: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = StFold;
        end
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        priority if (lastblk_q) begin
          state_d = StOut;
          idx_d   = '0;
        end else if (fin_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          cmd_o.rotate = 1'b1;
          idx_d        = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            fin_d         = 1'b0;
            lastblk_d     = 1'b0;
            state_d       = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ph_q      <= PhMark;
      rnd_q     <= '0;
      idx_q     <= '0;
      fin_q     <= 1'b0;
      lastblk_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ph_q      <= ph_d;
      rnd_q     <= rnd_d;
      idx_q     <= idx_d;
      fin_q     <= fin_d;
      lastblk_q <= lastblk_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign word_idx_o  = idx_q;

  // rounds always start from zero
  a_rnd_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.comp_start |-> rnd_q == 6'd0)
    else $error("round counter not zero at block start");

  // the length block is only reached while finalizing
  a_lastblk_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lastblk_q |-> fin_q)
    else $error("length block without finalization");

endmodule

/* design/sha256_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, eight digest words out per message.
// ----------------------------------------------------------------------------
// Input channel: one request per message byte (byte_valid=1); the final
// byte carries last. An empty message is a request with byte_valid=0 and
// last=1; byte_valid=0 with last=0 is taken and ignored.
// Throughput: one byte per cycle while a block fills. The byte that
// completes a block stalls the input while the 64 rounds run on the
// single round unit and the result is folded into the chain value.
// On last, padding bytes go through the same byte path, one per cycle:
// up to 64 + 8 bytes from the current position, each full block again
// compressed and folded as above. Then the output channel presents the
// eight digest words, index 0 first, one per cycle when not stalled;
// input stays stalled until the eighth word is taken, after which the
// hasher is back at the initial hash values.
// Output stall simply holds the current word; nothing is lost.
// Reset: chain value to the initial hash values, counts cleared, idle.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher import shb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  shb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output shb_out_t out_data_o
);

  shb_cmd_t   cmd;
  shb_sts_t   sts;
  logic [2:0] word_idx;
  logic [31:0] digest_word;

  shb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_idx_o  (word_idx),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  shb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_data_i.data_byte),
    .sts_o         (sts),
    .digest_word_o (digest_word)
  );

  assign out_data_o.digest_word = digest_word;
  assign out_data_o.word_index  = word_idx;
  assign out_data_o.last_word   = (word_idx == 3'd7);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while digest pending");

  a_word_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_word) |=>
      (out_valid_o && out_data_o.word_index == 3'($past(out_data_o.word_index) + 3'd1)))
    else $error("digest word sequence broken");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_word) |=> !in_stall_o)
    else $error("not idle after final digest word");

endmodule

/* tb/sv/tb_sha256_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// Self-checking bench for the SHA-256 byte stream hasher: a short table of
// directed requests, then random messages, some around the padding boundaries.
// Every digest word is checked against a local SHA-256 predictor, or against
// a typed-in digest for well-known messages.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher import shb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 220;
  localparam int          RAND_ITEMS  = 220;
  localparam int          MAX_REPORTS = 10;
  localparam int          BLK_LEN     = 64;
  localparam int          LEN_AT      = 56;
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam logic [63:0] BLK_BITS    = 64'd512;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // known == 0: digest comes from the predictor
  typedef struct packed {
    shb_in_t       req;
    logic [255:0]  known;
  } dir_row_t;

  localparam int N_DIR = 14;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{8'hff, 1'b0, 1'b0}, '0},            // idle request, ignored
    '{'{8'h00, 1'b0, 1'b1}, EMPTY_DIGEST},  // empty message right after reset
    '{'{8'h61, 1'b1, 1'b0}, '0},
    '{'{8'h62, 1'b1, 1'b0}, '0},
    '{'{8'h63, 1'b1, 1'b1}, ABC_DIGEST},
    '{'{8'h00, 1'b1, 1'b0}, '0},
    '{'{8'hff, 1'b1, 1'b0}, '0},
    '{'{8'h5a, 1'b0, 1'b1}, '0},            // separate end marker after bytes
    '{'{8'h55, 1'b1, 1'b0}, '0},
    '{'{8'haa, 1'b0, 1'b0}, '0},            // idle inside a message
    '{'{8'h80, 1'b1, 1'b1}, '0},
    '{'{8'hff, 1'b1, 1'b1}, '0},            // one-byte message
    '{'{8'h00, 1'b0, 1'b1}, EMPTY_DIGEST},  // empty again, back to back
    '{'{8'h00, 1'b1, 1'b1}, '0}
  };

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         in_valid  = 1'b0;
  logic         in_stall;
  shb_in_t      in_data   = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  shb_out_t     out_data;
  logic [255:0] req_known = '0;

  int           tx_gap_pct;
  int           rx_stall_pct;
  int           cycles    = 0;
  int           bad_cnt   = 0;
  int           n_req     = 0;
  int           n_msg     = 0;
  int           n_word    = 0;

  shb_out_t     digest_q [$];

  // predictor state
  logic [31:0]  chain_h   [8];
  logic [7:0]   blk_bytes [BLK_LEN];
  logic [5:0]   blk_fill;
  logic [63:0]  msg_bits;

  sha256_byte_stream_hasher DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hasher_reset();
    chain_h  = SHA_IV;
    blk_fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int          t;
    for (t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (t = 16; t < 64; t++) begin
      s0   = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1   = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = chain_h;
    for (t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++)
      chain_h[t] = chain_h[t] + v[t];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    if (blk_fill == 6'd63) begin
      compress_blk();
      msg_bits = msg_bits + BLK_BITS;
      blk_fill = '0;
    end else begin
      blk_fill = blk_fill + 6'd1;
    end
  endfunction

  function automatic logic [255:0] finish_msg();
    logic [63:0]  total;
    logic [255:0] dig;
    int           i;
    total = msg_bits + {55'd0, blk_fill, 3'd0};
    i = int'(blk_fill);
    blk_bytes[i] = PAD_MARK;
    i++;
    // no room for the length field: pad out and spill into a second block
    if (i > LEN_AT) begin
      while (i < BLK_LEN) begin
        blk_bytes[i] = 8'h00;
        i++;
      end
      compress_blk();
      i = 0;
    end
    while (i < LEN_AT) begin
      blk_bytes[i] = 8'h00;
      i++;
    end
    for (i = 0; i < 8; i++)
      blk_bytes[LEN_AT + i] = total[63 - 8*i -: 8];
    compress_blk();
    dig = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
           chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    hasher_reset();
    return dig;
  endfunction

  // Returns 1 when the request closes a message; dig then holds the digest.
  function automatic logic sha_step(input shb_in_t r, output logic [255:0] dig);
    dig = '0;
    if (r.byte_valid)
      absorb_byte(r.data_byte);
    if (!r.last)
      return 1'b0;
    dig = finish_msg();
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input shb_out_t exp_w,
                                        input shb_out_t got_w);
    bad_cnt++;
    if (bad_cnt <= MAX_REPORTS)
      $display("%0t: %s: expected word %08h idx %0d last %0b, got word %08h idx %0d last %0b",
               $realtime, what, exp_w.digest_word, exp_w.word_index, exp_w.last_word,
               got_w.digest_word, got_w.word_index, got_w.last_word);
  endfunction

  always @(posedge clk) begin : monitor
    logic [255:0] dig;
    shb_out_t     exp_w;
    int           k;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_req++;
        if (sha_step(in_data, dig)) begin
          n_msg++;
          if (req_known != '0)
            dig = req_known;
          for (k = 0; k < 8; k++) begin
            exp_w.digest_word = dig[255 - 32*k -: 32];
            exp_w.word_index  = k[2:0];
            exp_w.last_word   = (k == 7);
            digest_q.push_back(exp_w);
          end
        end
      end
      if (out_valid && !out_stall) begin
        n_word++;
        if (digest_q.size() == 0) begin
          note_mismatch("digest word with nothing pending", '0, out_data);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_data.digest_word !== exp_w.digest_word ||
              out_data.word_index !== exp_w.word_index ||
              out_data.last_word !== exp_w.last_word)
            note_mismatch("digest mismatch", exp_w, out_data);
        end
      end
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < rx_stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words pending", cycles, digest_q.size());
      $display("FAIL sha256_byte_stream_hasher");
      $finish;
    end
  end

  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        tx_gap_pct   = 6;
        rx_stall_pct = 85;
      end
      1: begin
        tx_gap_pct   = 85;
        rx_stall_pct = 6;
      end
      default: begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_req(input shb_in_t r, input logic [255:0] known);
    while ($urandom_range(99) < tx_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_data   <= r;
    req_known <= known;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // hold the sender off until every digest word has been taken
  task automatic drain_digests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digest_q.size() != 0)
      @(negedge clk);
  endtask

  function automatic int pick_len();
    if ($urandom_range(99) < 22) begin
      // around the point where padding needs an extra block
      case ($urandom_range(6))
        0:       return 55;
        1:       return 56;
        2:       return 57;
        3:       return 63;
        4:       return 64;
        5:       return 65;
        default: return int'($urandom_range(128, 119));
      endcase
    end
    return int'($urandom_range(12, 0));
  endfunction

  // returns the number of message byte requests sent, plus the separate end marker if any
  task automatic send_msg(input int len, output int n_sent);
    shb_in_t r;
    bit      sep_end;
    int      i;
    sep_end = (len == 0) || ($urandom_range(3) == 0);
    n_sent  = 0;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        r.data_byte  = 8'($urandom_range(255));
        r.byte_valid = 1'b0;
        r.last       = 1'b0;
        send_req(r, '0);
      end
      r.data_byte  = 8'($urandom_range(255));
      r.byte_valid = 1'b1;
      r.last       = !sep_end && (i == len - 1);
      send_req(r, '0);
      n_sent++;
    end
    if (sep_end) begin
      r.data_byte  = 8'($urandom_range(255));
      r.byte_valid = 1'b0;
      r.last       = 1'b1;
      send_req(r, '0);
      n_sent++;
    end
  endtask

  initial begin : stimulus
    int row;
    int sent;
    int n;
    int phase;
    hasher_reset();
    set_idling(0);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < N_DIR; row++)
      send_req(DIR_TAB[row].req, DIR_TAB[row].known);
    drain_digests();

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      if (sent * 3 / RAND_ITEMS != phase) begin
        drain_digests();
        phase = sent * 3 / RAND_ITEMS;
        set_idling(phase);
      end
      send_msg(pick_len(), n);
      sent += n;
    end

    drain_digests();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (digest_q.size() != 0) begin
      $display("%0d digest words never arrived", digest_q.size());
      bad_cnt++;
    end
    $display("covered %0d requests, %0d messages, %0d digest words; %0d mismatches",
             n_req, n_msg, n_word, bad_cnt);
    $display("idling: light sender/heavy receiver, the reverse, then back to back");
    if (bad_cnt == 0)
      $display("PASS sha256_byte_stream_hasher");
    else
      $display("FAIL sha256_byte_stream_hasher");
    $finish;
  end

endmodule
